[hdl/teletext_packet_page_store_top_defines.svh]
// assertion macros for the teletext page store
`ifndef TELETEXT_PACKET_PAGE_STORE_TOP_DEFINES_SVH
`define TELETEXT_PACKET_PAGE_STORE_TOP_DEFINES_SVH

`ifndef SYNTH

// property holds at every clock edge outside reset
`define TTXPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition never holds outside reset
`define TTXPS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define TTXPS_ASSERT(lbl, prop, msg)
`define TTXPS_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

[hdl/ttxps_pkg.sv]
package ttxps_pkg;

  // store geometry
  localparam int MAGAZINES = 8;
  localparam int PAGES     = 100;
  localparam int ROWS      = 32;
  localparam int COLUMNS   = 40;

  localparam int ROW_DEPTH = MAGAZINES * PAGES * ROWS;
  localparam int ROW_AW    = $clog2(ROW_DEPTH);
  localparam int ROW_BITS  = COLUMNS * 8;
  localparam int COL_W     = $clog2(COLUMNS);

  // packet framing
  localparam int LAST_POSITION  = 42;
  localparam int POS_W          = $clog2(LAST_POSITION + 1);
  localparam int FIRST_DATA_POS = 2;

  // header handling
  localparam int UNITS_IDX       = 0;
  localparam int TENS_IDX        = 1;
  localparam int ERASE_IDX       = 3;
  localparam int PAGE_TENS       = 10;
  localparam int ERASE_FIRST_ROW = 1;
  localparam int ERASE_LAST_ROW  = 28;
  localparam int LAST_TEXT_ROW   = 25;

  localparam logic [7:0] SPACE_CHAR  = 8'h20;
  localparam logic [7:0] PARITY_FAIL = 8'hFF;

  // operation codes
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic       ok;
    logic [3:0] nibble;   // 4'hF when not decodable
  } ham_res_t;

  typedef struct packed {
    logic                we;
    logic [ROW_AW-1:0]   waddr;
    logic [ROW_BITS-1:0] wdata;
    logic                re;
    logic [ROW_AW-1:0]   raddr;
  } ram_req_t;

  function automatic logic [ROW_AW-1:0] row_addr(logic [2:0] mag, logic [7:0] page,
                                                 logic [4:0] row);
    logic [ROW_AW-1:0] a;
    a = ROW_AW'(mag) * ROW_AW'(PAGES) + ROW_AW'(page);
    a = a * ROW_AW'(ROWS) + ROW_AW'(row);
    return a;
  endfunction

  function automatic logic row_in_range(logic [2:0] mag, logic [7:0] page, logic [4:0] row);
    return (32'(mag) < MAGAZINES) && (32'(page) < PAGES) && (32'(row) < ROWS);
  endfunction

endpackage

[hdl/teletext_packet_page_store_top.sv]
// channel | direction | handshake              | payload
// in      | to block  | in_valid_i / in_stall_o | operation_i, packet_byte_i, packet_start_i,
//         |           |                         | read_magazine_i, read_page_i, read_row_i,
//         |           |                         | read_column_i
// out     | from block| out_valid_o/out_stall_i | cell_value_o
//
// address bytes and header words without the erase bit need no memory access; a stored character
// is a row read, then the merged row written back; a read also waits on the output register
// a header word with the erase bit starts 28 whole-row writes of spaces, rows 1 to 28
// the row memory port takes one row read or one row write per cycle
// after reset a clearing pass writes zero to all 25600 rows, one per cycle, with
// in_stall_o high for the whole pass
// a finished read sits in the output register while the next word is taken
`include "teletext_packet_page_store_top_defines.svh"

module teletext_packet_page_store_top import ttxps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       operation_i,
  input  logic [7:0] packet_byte_i,
  input  logic       packet_start_i,
  input  logic [2:0] read_magazine_i,
  input  logic [6:0] read_page_i,
  input  logic [4:0] read_row_i,
  input  logic [5:0] read_column_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] cell_value_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_ERASE
  } state_e;

  state_e state_q;

  // packet parser state
  logic [POS_W-1:0]  pos_q;
  logic [7:0]        held_addr_q;
  logic [2:0]        mag_q;
  logic [4:0]        row_q;
  logic [7:0]        page_q;
  logic [3:0]        units_q;
  logic              dropped_q;

  // memory sequencing
  logic [ROW_AW-1:0] clr_q;
  logic [4:0]        er_row_q;
  logic [ROW_AW-1:0] wr_addr_q;
  logic [COL_W-1:0]  wr_col_q;
  logic [7:0]        wr_val_q;
  logic              rd_ok_q;
  logic [COL_W-1:0]  rd_col_q;

  // output register
  logic              out_valid_q;
  logic [7:0]        cell_q;

  ham_res_t            byte_ham, held_ham;
  ram_req_t            ram_req;
  logic [ROW_BITS-1:0] rd_row;
  logic [ROW_BITS-1:0] merged_row;
  logic [7:0]          rd_lane;

  logic             in_acc, pkt_acc, rd_acc;
  logic [POS_W-1:0] pos_eff;
  logic [POS_W-1:0] data_idx;
  logic             in_data;
  logic             erase_go, wr_go, rd_ok;
  logic [7:0]       char_val;

  ttxps_ham84 u_byte_ham (
    .code_i (packet_byte_i),
    .res_o  (byte_ham)
  );

  ttxps_ham84 u_held_ham (
    .code_i (held_addr_q),
    .res_o  (held_ham)
  );

  ttxps_row_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (rd_row)
  );

  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign pkt_acc      = in_acc && (operation_i == OP_PACKET);
  assign rd_acc       = in_acc && (operation_i == OP_READ);
  assign out_valid_o  = out_valid_q;
  assign cell_value_o = cell_q;

  // packet_start forces the first address byte
  assign pos_eff  = packet_start_i ? '0 : pos_q;
  assign data_idx = pos_eff - POS_W'(FIRST_DATA_POS);
  assign in_data  = (pos_eff >= POS_W'(FIRST_DATA_POS)) && (pos_eff < POS_W'(LAST_POSITION))
                    && !dropped_q;

  // header erase bit, only for a page that exists in the store
  assign erase_go = pkt_acc && in_data && (row_q == '0) && (data_idx == POS_W'(ERASE_IDX))
                    && byte_ham.nibble[3] && row_in_range(mag_q, page_q, 5'(ERASE_LAST_ROW));

  // text rows store odd-parity characters
  assign wr_go = pkt_acc && in_data && (row_q != '0) && (row_q <= 5'(LAST_TEXT_ROW))
                 && row_in_range(mag_q, page_q, row_q);

  assign char_val = (^packet_byte_i)
                    ? {1'b0, packet_byte_i[1], packet_byte_i[2], packet_byte_i[3],
                       packet_byte_i[4], packet_byte_i[5], packet_byte_i[6], packet_byte_i[7]}
                    : PARITY_FAIL;

  assign rd_ok = row_in_range(read_magazine_i, {1'b0, read_page_i}, read_row_i)
                 && (32'(read_column_i) < COLUMNS);

  // lane pick for reads and lane replace for the write-back
  always_comb begin
    rd_lane    = '0;
    merged_row = rd_row;
    for (int l = 0; l < COLUMNS; l++) begin
      if (COL_W'(l) == rd_col_q) rd_lane = rd_row[l*8 +: 8];
      if (COL_W'(l) == wr_col_q) merged_row[l*8 +: 8] = wr_val_q;
    end
  end

  // memory port requests
  always_comb begin
    ram_req = '0;
    case (state_q)
      ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_q;
      end
      ST_IDLE: begin
        if (rd_acc && rd_ok) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = row_addr(read_magazine_i, {1'b0, read_page_i}, read_row_i);
        end else if (wr_go) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = row_addr(mag_q, page_q, row_q);
        end
      end
      ST_WRITE: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = wr_addr_q;
        ram_req.wdata = merged_row;
      end
      ST_ERASE: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = row_addr(mag_q, page_q, er_row_q);
        ram_req.wdata = {COLUMNS{SPACE_CHAR}};
      end
      default: ram_req = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      pos_q       <= '0;
      held_addr_q <= '0;
      mag_q       <= '0;
      row_q       <= '0;
      page_q      <= '0;
      units_q     <= '0;
      dropped_q   <= 1'b0;
      clr_q       <= '0;
      er_row_q    <= '0;
      wr_addr_q   <= '0;
      wr_col_q    <= '0;
      wr_val_q    <= '0;
      rd_ok_q     <= 1'b0;
      rd_col_q    <= '0;
      out_valid_q <= 1'b0;
      cell_q      <= '0;
    end else begin
      // output word taken downstream, a finishing read refills it below
      if (out_valid_q && !out_stall_i && (state_q != ST_READ)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == ROW_AW'(ROW_DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (rd_acc) begin
            rd_ok_q  <= rd_ok;
            rd_col_q <= read_column_i[COL_W-1:0];
            state_q  <= ST_READ;
          end else if (pkt_acc) begin
            if (pos_eff == '0) begin
              held_addr_q <= packet_byte_i;
              dropped_q   <= 1'b0;
              pos_q       <= POS_W'(1);
            end else if (pos_eff == POS_W'(1)) begin
              // bad magazine byte drops the packet and keeps magazine and row
              if (!held_ham.ok) begin
                dropped_q <= 1'b1;
              end else begin
                mag_q <= held_ham.nibble[2:0];
                row_q <= {byte_ham.nibble, held_ham.nibble[3]};
              end
              pos_q <= POS_W'(FIRST_DATA_POS);
            end else if (pos_eff < POS_W'(LAST_POSITION)) begin
              if (in_data && (row_q == '0)) begin
                if (data_idx == POS_W'(UNITS_IDX)) begin
                  units_q <= byte_ham.nibble;
                end else if (data_idx == POS_W'(TENS_IDX)) begin
                  page_q <= 8'(8'(byte_ham.nibble) * 8'(PAGE_TENS) + 8'(units_q));
                end
              end
              pos_q <= pos_eff + 1'b1;
            end else begin
              pos_q <= POS_W'(LAST_POSITION);
            end

            if (wr_go) begin
              wr_addr_q <= row_addr(mag_q, page_q, row_q);
              wr_col_q  <= data_idx[COL_W-1:0];
              wr_val_q  <= char_val;
              state_q   <= ST_WRITE;
            end else if (erase_go) begin
              er_row_q <= 5'(ERASE_FIRST_ROW);
              state_q  <= ST_ERASE;
            end
          end
        end

        ST_READ: begin
          // row data is held until the output register frees up
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            cell_q      <= rd_ok_q ? rd_lane : 8'h00;
            state_q     <= ST_IDLE;
          end
        end

        ST_WRITE: begin
          state_q <= ST_IDLE;
        end

        ST_ERASE: begin
          er_row_q <= er_row_q + 1'b1;
          if (er_row_q == 5'(ERASE_LAST_ROW)) begin
            state_q <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `TTXPS_ASSERT_NEVER(a_ram_one_access, ram_req.we && ram_req.re,
                      "row read and write together")
  `TTXPS_ASSERT(a_erase_rows,
                (state_q == ST_ERASE) |-> ((er_row_q >= 5'(ERASE_FIRST_ROW))
                                           && (er_row_q <= 5'(ERASE_LAST_ROW))),
                "erase row out of range")
  `TTXPS_ASSERT(a_bad_read_zero,
                ((state_q == ST_READ) && !rd_ok_q && !(out_valid_q && out_stall_i))
                |=> (out_valid_q && (cell_q == 8'h00)),
                "out-of-range read not zero")
  `TTXPS_ASSERT(a_write_follows_read,
                (state_q == ST_WRITE) |-> ($past(state_q) == ST_IDLE),
                "write-back without row read")
  `TTXPS_ASSERT_NEVER(a_pos_bound, pos_q > POS_W'(LAST_POSITION),
                      "byte position past packet end")

endmodule

[hdl/ttxps_ham84.sv]
module ttxps_ham84 import ttxps_pkg::*; (
  input  logic [7:0] code_i,
  output ham_res_t   res_o
);

  logic       chk_a, chk_b, chk_c, chk_d;
  logic       ok;
  logic [2:0] flip_idx;
  logic [7:0] fixed;

  assign chk_a = ^(code_i & 8'hC5);
  assign chk_b = ^(code_i & 8'h71);
  assign chk_c = ^(code_i & 8'h5C);
  assign chk_d = ^code_i;

  always_comb begin
    ok       = 1'b1;
    flip_idx = 3'd6;
    fixed    = code_i;
    if (chk_a && chk_b && chk_c) begin
      // only the whole-byte parity bit can be wrong
      fixed = chk_d ? code_i : (code_i ^ 8'h02);
    end else if (chk_d) begin
      ok = 1'b0;   // double error
    end else begin
      if (chk_a && chk_b)      flip_idx = 3'd3;
      else if (chk_a && chk_c) flip_idx = 3'd5;
      else if (chk_b && chk_c) flip_idx = 3'd7;
      else if (chk_c)          flip_idx = 3'd0;
      else if (chk_b)          flip_idx = 3'd2;
      else if (chk_a)          flip_idx = 3'd4;
      else                     flip_idx = 3'd6;
      fixed = code_i ^ (8'd1 << flip_idx);
    end
  end

  assign res_o.ok     = ok;
  assign res_o.nibble = ok ? {fixed[0], fixed[2], fixed[4], fixed[6]} : 4'hF;

endmodule

[hdl/ttxps_row_ram.sv]
module ttxps_row_ram import ttxps_pkg::*; (
  input  logic                clk_i,
  input  ram_req_t            req_i,
  output logic [ROW_BITS-1:0] rd_data_o
);

  // one entry holds a whole text row
  logic [ROW_BITS-1:0] mem_q [ROW_DEPTH];
  logic [ROW_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem_q[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
